### rtl/wgm_pkg.sv
// Shared types and constants for the wildcard glob matcher.
// Used by the matcher cell and the top level; depends on nothing else.
`default_nettype none

package wgm_pkg;

	localparam int PATTERN_MAX_DEF = 32;

	localparam logic [7:0] CH_STAR     = 8'd42;
	localparam logic [7:0] CH_QUESTION = 8'd63;

	typedef enum logic [1:0] {
		FUNC_CLEAR   = 2'd0,
		FUNC_APPEND  = 2'd1,
		FUNC_SUBJECT = 2'd2,
		FUNC_END     = 2'd3
	} func_t;

	// Command broadcast from the top level to every cell in the row.
	typedef struct packed {
		logic       accept;
		func_t      func;
		logic [7:0] ch;
	} cmd_t;

endpackage

`default_nettype wire

### rtl/wgm_cell.sv
// One position of the glob matcher row: a pattern byte, its valid bit and its live bit.
// Depends on wgm_pkg; instantiated once per pattern position by the top level.
`default_nettype none

module wgm_cell
	import wgm_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire cmd_t cmd,
	input  wire logic first,      // Tied high for position zero only.
	input  wire logic prev_valid, // Left neighbor holds a pattern byte.
	input  wire logic carry_in,   // Star closure arriving from the left.
	input  wire logic adv_in,     // Left neighbor matched the current byte.
	output logic      valid,
	output logic      carry_out,
	output logic      adv_out,
	output logic      end_hit
);

	logic       live_q;
	logic       valid_q;
	logic [7:0] pat_q;
	logic       closed;
	logic       is_star;
	logic       byte_ok;
	logic       load;

	assign is_star = (pat_q == CH_STAR);
	assign byte_ok = (pat_q == cmd.ch) || (pat_q == CH_QUESTION);

	// A live position that holds a star makes the next position live in the same cycle.
	assign closed    = live_q | carry_in;
	assign carry_out = closed & valid_q & is_star;
	assign adv_out   = closed & valid_q & ~is_star & byte_ok;

	// The first empty position is the end of the pattern.
	assign end_hit = closed & ~valid_q & prev_valid;
	assign valid   = valid_q;

	assign load = cmd.accept && (cmd.func == FUNC_APPEND) && prev_valid && !valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q  <= first;
			valid_q <= 1'b0;
		end else if (cmd.accept) begin
			case (cmd.func) inside
				FUNC_SUBJECT: begin
					live_q <= (closed & valid_q & is_star) | adv_in;
				end
				FUNC_CLEAR, FUNC_APPEND, FUNC_END: begin
					live_q <= first;
				end
				default: begin
					live_q <= live_q;
				end
			endcase
			if (cmd.func == FUNC_CLEAR) begin
				valid_q <= 1'b0;
			end else if (load) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			pat_q <= cmd.ch;
		end
	end

endmodule

`default_nettype wire

### rtl/wildcard_glob_matcher_unit.sv
// Top level of the wildcard glob matcher: a row of wgm_cell and a one-item output register.
// Depends on wgm_pkg and wgm_cell.
//
// The matcher takes one item per clock cycle of any kind: clear the pattern, append a pattern
// byte, feed a subject byte, or end the subject. Only an end item yields a result, which
// appears on the output register in the cycle after it is accepted; the input keeps
// flowing while that result waits, stalling only when a result is held and not taken.
// Each pattern position is one cell that holds its byte and its live bit; a subject byte
// updates all cells at once, and runs of stars are resolved by a closure signal rippling
// along the row, so that ripple over PATTERN_MAX cells sets the clock period. Appending past
// PATTERN_MAX bytes drops the byte and sets overflow until the next clear; a result then
// never reports a match. There is no clearing pass after reset.
`default_nettype none

module wildcard_glob_matcher_unit
	import wgm_pkg::*;
#(
	parameter int PATTERN_MAX = PATTERN_MAX_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,  // [7:0] ch
	input  wire logic [1:0] s_tuser,  // [1:0] func
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata   // [0] matched, [1] overflow, [7:2] zero
);

	cmd_t                   cmd;
	logic                   accept;
	logic [PATTERN_MAX-1:0] valid;
	logic [PATTERN_MAX-1:0] prev_valid;
	logic [PATTERN_MAX:0]   carry;
	logic [PATTERN_MAX:0]   adv;
	logic [PATTERN_MAX-1:0] end_hit;
	logic                   live_last_q;
	logic                   closed_last;
	logic                   hit;
	logic                   overflow_q;
	logic                   m_valid_q;
	logic                   matched_q;
	logic                   ovf_out_q;

	assign s_tready = ~m_valid_q | m_tready;
	assign accept   = s_tvalid & s_tready;

	assign cmd.accept = accept;
	assign cmd.func   = func_t'(s_tuser);
	assign cmd.ch     = s_tdata;

	assign carry[0]   = 1'b0;
	assign adv[0]     = 1'b0;
	assign prev_valid = {valid[PATTERN_MAX-2:0], 1'b1};

	for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cell
		wgm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.cmd       (cmd),
			.first     ((i == 0) ? 1'b1 : 1'b0),
			.prev_valid(prev_valid[i]),
			.carry_in  (carry[i]),
			.adv_in    (adv[i]),
			.valid     (valid[i]),
			.carry_out (carry[i+1]),
			.adv_out   (adv[i+1]),
			.end_hit   (end_hit[i])
		);
	end

	// The position past a full pattern has no byte of its own, only a live bit.
	assign closed_last = live_last_q | carry[PATTERN_MAX];
	assign hit         = (|end_hit) | (valid[PATTERN_MAX-1] & closed_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_last_q <= 1'b0;
			overflow_q  <= 1'b0;
			m_valid_q   <= 1'b0;
		end else begin
			if (accept) begin
				unique case (cmd.func)
					FUNC_CLEAR: begin
						live_last_q <= 1'b0;
						overflow_q  <= 1'b0;
					end
					FUNC_APPEND: begin
						live_last_q <= 1'b0;
						if (valid[PATTERN_MAX-1]) begin
							overflow_q <= 1'b1;
						end
					end
					FUNC_SUBJECT: begin
						live_last_q <= adv[PATTERN_MAX];
					end
					FUNC_END: begin
						live_last_q <= 1'b0;
					end
					default: begin
						live_last_q <= live_last_q;
					end
				endcase
			end
			if (s_tready) begin
				m_valid_q <= accept && (cmd.func == FUNC_END);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready) begin
			matched_q <= hit & ~overflow_q;
			ovf_out_q <= overflow_q;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {6'b000000, ovf_out_q, matched_q};

endmodule

`default_nettype wire

### rtl/wgm_checker.sv
// Port-level assertions for the wildcard glob matcher and the bind that attaches them.
// Depends on wgm_pkg and on wildcard_glob_matcher_unit only through its ports.
`default_nettype none

module wgm_checker
	import wgm_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tvalid,
	input wire logic       s_tready,
	input wire logic [1:0] s_tuser,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata
);

	// A held result stays offered until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result item dropped while stalled");

	a_ovf_no_match: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1] |-> !m_tdata[0])
		else $error("match reported with overflowed pattern");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with an empty output register");

	a_end_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == FUNC_END |=> m_tvalid)
		else $error("end item produced no result");

	a_other_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser != FUNC_END && (!m_tvalid || m_tready)
		|=> !m_tvalid)
		else $error("result without an end item");

endmodule

bind wildcard_glob_matcher_unit wgm_checker u_wgm_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.s_tuser (s_tuser),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

`default_nettype wire

### tb/tb_wildcard_glob_matcher_unit.sv
// Self-checking testbench for wildcard_glob_matcher_unit: streams pattern and subject items,
// predicts each end-of-subject verdict and compares it with the result stream.
// Depends on wgm_pkg and the matcher RTL.
`default_nettype none

module tb_wildcard_glob_matcher_unit;
	import wgm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PATTERN_MAX = PATTERN_MAX_DEF;
	localparam int ITEM_TARGET = 1500;
	localparam int CALM_TAIL   = 120;
	localparam int CYCLE_LIMIT = 200000;
	localparam int TAIL_CYCLES = 20;

	localparam logic [PATTERN_MAX:0] LIVE_START = (PATTERN_MAX + 1)'(1);

	typedef struct packed {
		func_t      func;
		logic [7:0] ch;
	} glob_item_t;

	typedef struct packed {
		logic matched;
		logic overflow;
	} verdict_t;

	logic       clk      = 1'b0;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'd0;  // [7:0] ch
	logic [1:0] s_tuser  = 2'd0;  // [1:0] func
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;          // [0] matched, [1] overflow, [7:2] zero

	wildcard_glob_matcher_unit #(
		.PATTERN_MAX(PATTERN_MAX)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #5 clk = ~clk;

	glob_item_t pending_items[$];
	verdict_t   verdicts_due[$];
	int         planned_items = 0;

	// Predicted matcher state.
	logic [7:0]         pat_bytes [PATTERN_MAX];
	int                 pat_len      = 0;
	logic [PATTERN_MAX:0] live_set   = LIVE_START;
	logic               pat_overflow = 1'b0;

	int errors         = 0;
	int accepted_items = 0;
	int results_seen   = 0;
	int hits_seen      = 0;
	int overflow_seen  = 0;
	int gap_left       = 0;
	int stall_left     = 0;
	int cycles         = 0;

	function automatic logic [PATTERN_MAX:0] close_stars(input logic [PATTERN_MAX:0] v);
		logic [PATTERN_MAX:0] r;
		r = v;
		for (int i = 0; i < pat_len; i++) begin
			if (r[i] && pat_bytes[i] == CH_STAR)
				r[i + 1] = 1'b1;
		end
		return r;
	endfunction

	task automatic predict_item(input func_t f, input logic [7:0] c);
		logic [PATTERN_MAX:0] nxt;
		verdict_t v;
		case (f)
			FUNC_CLEAR: begin
				pat_len = 0;
				pat_overflow = 1'b0;
				live_set = LIVE_START;
			end
			FUNC_APPEND: begin
				if (pat_len < PATTERN_MAX) begin
					pat_bytes[pat_len] = c;
					pat_len++;
				end else begin
					pat_overflow = 1'b1;
				end
				live_set = LIVE_START;
			end
			FUNC_SUBJECT: begin
				live_set = close_stars(live_set);
				nxt = '0;
				for (int i = 0; i < pat_len; i++) begin
					if (live_set[i]) begin
						if (pat_bytes[i] == CH_STAR)
							nxt[i] = 1'b1;
						else if (pat_bytes[i] == c || pat_bytes[i] == CH_QUESTION)
							nxt[i + 1] = 1'b1;
					end
				end
				live_set = close_stars(nxt);
			end
			default: begin
				live_set = close_stars(live_set);
				v.matched = live_set[pat_len] && !pat_overflow;
				v.overflow = pat_overflow;
				verdicts_due = {verdicts_due, v};
				live_set = LIVE_START;
			end
		endcase
	endtask

	task automatic push_item(input func_t f, input logic [7:0] c);
		glob_item_t it;
		it.func = f;
		it.ch = c;
		pending_items = {pending_items, it};
		planned_items++;
	endtask

	function automatic logic [7:0] pick_letter();
		logic [7:0] r;
		case ($urandom_range(0, 3))
			0: r = "a";
			1: r = "b";
			2: r = "c";
			default: r = 8'($urandom_range(1, 255));
		endcase
		return r;
	endfunction

	// One pattern followed by a few subjects, most of them built to match it.
	task automatic plan_scenario(input int forced_len);
		logic [7:0] pat[$];
		logic [7:0] subj[$];
		int len;
		int sel;
		int n_subj;
		int mode;
		int pos;
		push_item(FUNC_CLEAR, 8'($urandom_range(1, 255)));
		if (forced_len >= 0) begin
			len = forced_len;
		end else begin
			sel = $urandom_range(0, 19);
			if (sel == 0)
				len = PATTERN_MAX;
			else if (sel == 1)
				len = $urandom_range(PATTERN_MAX + 1, PATTERN_MAX + 4);
			else
				len = $urandom_range(0, 8);
		end
		for (int i = 0; i < len; i++) begin
			sel = $urandom_range(0, 9);
			if (sel < 3)
				pat = {pat, CH_STAR};
			else if (sel < 5)
				pat = {pat, CH_QUESTION};
			else
				pat = {pat, pick_letter()};
			push_item(FUNC_APPEND, pat[i]);
		end
		n_subj = $urandom_range(1, 4);
		for (int s = 0; s < n_subj; s++) begin
			subj.delete();
			mode = $urandom_range(0, 9);
			if (mode < 8) begin
				for (int i = 0; i < len && i < PATTERN_MAX; i++) begin
					if (pat[i] == CH_STAR) begin
						repeat ($urandom_range(0, 3)) subj = {subj, pick_letter()};
					end else if (pat[i] == CH_QUESTION) begin
						subj = {subj, pick_letter()};
					end else begin
						subj = {subj, pat[i]};
					end
				end
				if (mode >= 6) begin
					// Damage the subject so it usually misses.
					sel = $urandom_range(0, 2);
					if (sel == 0 && subj.size() > 0) begin
						pos = $urandom_range(0, subj.size() - 1);
						subj[pos] = pick_letter();
					end else if (sel == 1 && subj.size() > 0) begin
						void'(subj.pop_back());
					end else begin
						subj = {subj, pick_letter()};
					end
				end
			end else begin
				repeat ($urandom_range(0, 6)) subj = {subj, pick_letter()};
			end
			foreach (subj[i])
				push_item(FUNC_SUBJECT, subj[i]);
			push_item(FUNC_END, 8'($urandom_range(1, 255)));
		end
	endtask

	// Driver: presents pending items, holds an item while the block stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_item(func_t'(s_tuser), s_tdata);
				accepted_items <= accepted_items + 1;
			end
			if (s_tvalid && !s_tready) begin
				// Hold the current item.
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				s_tvalid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				if (pending_items.size() >= CALM_TAIL && $urandom_range(0, 9) == 0) begin
					gap_left <= $urandom_range(1, 5) - 1;
					s_tvalid <= 1'b0;
				end else begin
					s_tvalid <= 1'b1;
					s_tdata  <= pending_items[0].ch;
					s_tuser  <= pending_items[0].func;
					void'(pending_items.pop_front());
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Monitor: takes results with random back-pressure and checks each one.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			stall_left <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				results_seen <= results_seen + 1;
				if (m_tdata[0]) hits_seen <= hits_seen + 1;
				if (m_tdata[1]) overflow_seen <= overflow_seen + 1;
				if (verdicts_due.size() == 0) begin
					if (errors < 10)
						$display("ERROR: result %b with no verdict pending", m_tdata);
					errors <= errors + 1;
				end else begin
					if (m_tdata[0] !== verdicts_due[0].matched
							|| m_tdata[1] !== verdicts_due[0].overflow
							|| m_tdata[7:2] !== 6'd0) begin
						if (errors < 10)
							$display("ERROR: verdict %0d: expected matched=%b overflow=%b, got tdata=%b",
								results_seen, verdicts_due[0].matched,
								verdicts_due[0].overflow, m_tdata);
						errors <= errors + 1;
					end
					void'(verdicts_due.pop_front());
				end
			end
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				m_tready <= 1'b0;
			end else if (pending_items.size() >= CALM_TAIL && $urandom_range(0, 7) == 0) begin
				stall_left <= $urandom_range(1, 5) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("ERROR: timeout after %0d cycles", cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		// Directed: empty pattern, lone star, star then question, zero and top byte values.
		push_item(FUNC_END, 8'd1);
		push_item(FUNC_SUBJECT, 8'hFF);
		push_item(FUNC_END, 8'd1);
		push_item(FUNC_APPEND, CH_STAR);
		push_item(FUNC_END, 8'hFF);
		push_item(FUNC_APPEND, CH_QUESTION);
		push_item(FUNC_SUBJECT, 8'd0);
		push_item(FUNC_SUBJECT, 8'd1);
		push_item(FUNC_END, 8'd0);
		push_item(FUNC_SUBJECT, CH_STAR);
		push_item(FUNC_END, 8'd0);
		push_item(FUNC_CLEAR, 8'hFF);
		push_item(FUNC_APPEND, 8'd0);
		push_item(FUNC_SUBJECT, 8'd0);
		push_item(FUNC_END, 8'd1);
		push_item(FUNC_APPEND, 8'hFF);
		push_item(FUNC_SUBJECT, 8'd0);
		push_item(FUNC_SUBJECT, 8'hFF);
		push_item(FUNC_END, 8'd1);
		push_item(FUNC_SUBJECT, 8'h55);
		push_item(FUNC_END, 8'd1);
		push_item(FUNC_CLEAR, 8'd0);
		push_item(FUNC_SUBJECT, 8'hAA);
		push_item(FUNC_END, 8'd1);

		// A pattern that fills the store exactly, then one that runs past it.
		plan_scenario(PATTERN_MAX);
		plan_scenario(PATTERN_MAX + 2);
		while (planned_items < ITEM_TARGET) begin
			if ($urandom_range(0, 19) == 0) begin
				repeat ($urandom_range(1, 6))
					push_item(func_t'($urandom_range(0, 3)), 8'($urandom_range(1, 255)));
			end else begin
				plan_scenario(-1);
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_items.size() > 0 || s_tvalid)
			@(posedge clk);
		while (verdicts_due.size() > 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Covered %0d items and %0d verdicts (%0d matches, %0d with overflow).",
			accepted_items, results_seen, hits_seen, overflow_seen);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("Mismatches: %0d", errors);
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

`default_nettype wire
